// ----- rtl/spq_pkg.sv -----
// Shared constants and types for the sorted priority queue.
`default_nettype none

package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int PRI_W = 16;
   localparam int STS_W = 2;
   localparam int OCC_W = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [STS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STS_W-1:0] STATUS_UNDERFLOW = 2'd1;
   localparam logic [STS_W-1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic load;   // capture the incoming request beat
      logic exec;   // run the operation and load the result register
   } spq_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/spq_ctrl.sv -----
// Controller state machine: request capture, execution and result handshake.
`default_nettype none

module spq_ctrl
   import spq_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output spq_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.load     = req_tvalid && (state_ff == ST_IDLE);
      cmd.exec     = (state_ff == ST_EXEC) && out_free;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait here until the result register can take the new beat
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not move to execution");

   a_exec_gives_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("execution did not present a result beat");

   a_no_exec_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !cmd.exec)
      else $error("result overwritten while still waiting");
`endif

endmodule

`default_nettype wire

// ----- rtl/spq_datapath.sv -----
// Datapath: sorted entry cells with parallel compare-and-shift, and result register.
`default_nettype none

module spq_datapath
   import spq_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  spq_cmd_type             cmd,
   input  wire                     req_cmd,
   input  wire  [VAL_W-1:0]        req_value,
   input  wire  [PRI_W-1:0]        req_priority,
   output logic [STS_W-1:0]        rsp_status,
   output logic [VAL_W-1:0]        rsp_value,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   logic                    op_ff;
   logic [VAL_W-1:0]        new_val_ff;
   logic signed [PRI_W-1:0] new_pri_ff;

   logic [VAL_W-1:0]        val_ff [DEPTH];
   logic signed [PRI_W-1:0] pri_ff [DEPTH];
   logic [VAL_W-1:0]        val_in [DEPTH];
   logic signed [PRI_W-1:0] pri_in [DEPTH];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [DEPTH-1:0]        le;

   logic [STS_W-1:0]        status_ff, status_in;
   logic [VAL_W-1:0]        head_ff, head_in;
   logic [OCC_W-1:0]        occ_ff;

   logic is_full, is_empty, do_insert, do_remove;

   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign do_insert = (op_ff == CMD_INSERT) && !is_full;
   assign do_remove = (op_ff == CMD_REMOVE) && !is_empty;

   // each cell flags whether it is held and sorts at or before the new entry;
   // the flags form a prefix since the list is kept sorted
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i] = (CNT_W'(i) < count_ff) && (pri_ff[i] <= new_pri_ff);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         val_in[i] = val_ff[i];
         pri_in[i] = pri_ff[i];
         if (do_insert) begin
            if (!le[i]) begin
               if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
                  val_in[i] = new_val_ff;
                  pri_in[i] = new_pri_ff;
               end else begin
                  val_in[i] = val_ff[(i == 0) ? 0 : i - 1];
                  pri_in[i] = pri_ff[(i == 0) ? 0 : i - 1];
               end
            end
         end else if (do_remove) begin
            if (i < DEPTH - 1) begin
               val_in[i] = val_ff[(i < DEPTH - 1) ? i + 1 : i];
               pri_in[i] = pri_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      head_in   = '0;
      if (op_ff == CMD_INSERT) begin
         if (is_full) begin
            status_in = STATUS_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         if (is_empty) begin
            status_in = STATUS_UNDERFLOW;
         end else begin
            head_in  = val_ff[0];
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_cmd;
         new_val_ff <= req_value;
         new_pri_ff <= req_priority;
      end
      if (cmd.exec) begin
         for (int i = 0; i < DEPTH; i++) begin
            val_ff[i] <= val_in[i];
            pri_ff[i] <= pri_in[i];
         end
         status_ff <= status_in;
         head_ff   <= head_in;
         occ_ff    <= OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_value     = head_ff;
   assign rsp_occupancy = occ_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == CMD_INSERT && !is_full)
         |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not add an entry");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == CMD_REMOVE && !is_empty)
         |=> (count_ff == $past(count_ff) - CNT_W'(1) && status_ff == STATUS_OK))
      else $error("remove did not take an entry");
`endif

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: controller and datapath.
//
// channel  dir  tdata                                     tuser
// req_     in   [31:0] item_value, [47:32] item_priority   [0] cmd
// rsp_     out  [31:0] head_value, [36:32] occupancy        [1:0] status
//
// Each operation first captures the request beat; then every entry cell
// compares and shifts in parallel. Reset empties the queue at once; stored
// entries themselves are not cleared. While a result beat waits for
// rsp_tready the next request is still captured, but it only executes once
// the result register is free.
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // item_value [31:0], item_priority [47:32]
   input  wire  [0:0]  req_tuser,   // cmd [0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // head_value [31:0], occupancy [36:32], zero [39:37]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   spq_cmd_type      cmd;
   logic [VAL_W-1:0] head_value;
   logic [OCC_W-1:0] occupancy;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_cmd       (req_tuser[0]),
      .req_value     (req_tdata[31:0]),
      .req_priority  (req_tdata[47:32]),
      .rsp_status    (rsp_tuser),
      .rsp_value     (head_value),
      .rsp_occupancy (occupancy)
   );

   assign rsp_tdata = {3'b000, occupancy, head_value};

endmodule

`default_nettype wire

// ----- sim/sorted_priority_queue_tb.sv -----
// Self-checking testbench for the sorted priority queue: random insert/remove traffic.
`timescale 1ns / 1ps

module sorted_priority_queue_tb
   import spq_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_OPS  = 750;
   localparam int DRAIN_WAIT  = 20;

   typedef struct {
      logic                    cmd;
      logic [VAL_W-1:0]        value;
      logic signed [PRI_W-1:0] prio;
   } queue_op_type;

   typedef struct {
      logic [STS_W-1:0] status;
      logic [VAL_W-1:0] head;
      logic [OCC_W-1:0] occupancy;
   } queue_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;    // item_value [31:0], item_priority [47:32]
   logic [0:0]  req_tuser = '0;    // cmd [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // head_value [31:0], occupancy [36:32], zero [39:37]
   logic [1:0]  rsp_tuser;         // status [1:0]

   sorted_priority_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // shadow copy of the queue contents
   logic [VAL_W-1:0]        shadow_value [DEPTH];
   logic signed [PRI_W-1:0] shadow_prio  [DEPTH];
   int                      shadow_count = 0;

   queue_op_type     pending_ops[$];
   queue_result_type expected_results[$];

   int errors = 0;
   int cycles = 0;
   int beats_checked = 0;
   int n_insert = 0, n_dropped = 0, n_remove = 0, n_underflow = 0, peak_count = 0;

   int   send_gap = 0, recv_gap = 0, stretch_left = 0;
   logic calm = 1'b0, tail = 1'b0;
   logic next_valid;

   initial begin
      forever #2 clock = ~clock;
   end

   // apply one operation to the shadow queue and return the result it should produce
   function automatic queue_result_type apply_operation(queue_op_type op);
      queue_result_type res;
      int               pos;
      res.status = STATUS_OK;
      res.head   = '0;
      if (op.cmd == CMD_INSERT) begin
         n_insert++;
         if (shadow_count >= DEPTH) begin
            res.status = STATUS_FULL;
            n_dropped++;
         end else begin
            pos = 0;
            // equal priorities go behind the ones already held
            while (pos < shadow_count && shadow_prio[pos] <= op.prio) pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_value[i] = shadow_value[i-1];
               shadow_prio[i]  = shadow_prio[i-1];
            end
            shadow_value[pos] = op.value;
            shadow_prio[pos]  = op.prio;
            shadow_count++;
            if (shadow_count > peak_count) peak_count = shadow_count;
         end
      end else begin
         n_remove++;
         if (shadow_count == 0) begin
            res.status = STATUS_UNDERFLOW;
            n_underflow++;
         end else begin
            res.head = shadow_value[0];
            for (int i = 1; i < shadow_count; i++) begin
               shadow_value[i-1] = shadow_value[i];
               shadow_prio[i-1]  = shadow_prio[i];
            end
            shadow_count--;
         end
      end
      res.occupancy = shadow_count[OCC_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("mismatch on result beat %0d (cycle %0d): %s expected %0h got %0h",
               beats_checked, cycles, what, want, got);
   endtask

   task automatic check_result();
      queue_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("unexpected beat, tdata", 64'd0, {24'd0, rsp_tdata});
      end else begin
         want = expected_results.pop_front();
         if (rsp_tuser !== want.status)
            report_mismatch("status", 64'(want.status), 64'(rsp_tuser));
         if (rsp_tdata[31:0] !== want.head)
            report_mismatch("head_value", 64'(want.head), 64'(rsp_tdata[31:0]));
         if (rsp_tdata[36:32] !== want.occupancy)
            report_mismatch("occupancy", 64'(want.occupancy), 64'(rsp_tdata[36:32]));
         if (rsp_tdata[39:37] !== 3'd0)
            report_mismatch("padding", 64'd0, 64'(rsp_tdata[39:37]));
      end
      beats_checked++;
   endtask

   task automatic queue_op(logic cmd, logic [VAL_W-1:0] value, logic signed [PRI_W-1:0] prio);
      queue_op_type op;
      op.cmd   = cmd;
      op.value = value;
      op.prio  = prio;
      pending_ops.push_back(op);
   endtask

   function automatic logic signed [PRI_W-1:0] pick_prio();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 12) return PRI_W'($urandom_range(0, 6) - 3);   // narrow band, lots of ties
      if (sel < 17) return PRI_W'($urandom);
      case ($urandom_range(0, 3))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return -16'sd1;
         default: return 16'sd0;
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // stretches with and without idling; none once the stimulus is nearly through
   always @(posedge clock) begin
      if (stretch_left == 0) begin
         stretch_left <= $urandom_range(20, 150);
         calm <= ($urandom_range(0, 3) == 0);
      end else begin
         stretch_left <= stretch_left - 1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_results.size());
         $display("FAIL sorted_priority_queue");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tail       <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_operation(pending_ops.pop_front()));
         tail <= (pending_ops.size() < 80);
         if (!(req_tvalid && !req_tready)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (!calm && !tail && $urandom_range(0, 3) == 0) begin
               send_gap = $urandom_range(1, 11) - 1;
            end else if (pending_ops.size() > 0) begin
               next_valid = 1'b1;
               req_tdata  <= {pending_ops[0].prio, pending_ops[0].value};
               req_tuser  <= pending_ops[0].cmd;
            end
            req_tvalid <= next_valid;
         end
      end
   end

   // result monitor and back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && !tail && $urandom_range(0, 4) == 0) begin
            recv_gap = $urandom_range(1, 11) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int run_left;
      int insert_odds;

      // directed: empty remove, extremes, ties, fill to full, overflow, refill
      queue_op(CMD_REMOVE, 32'h0, 16'sh0);
      queue_op(CMD_INSERT, 32'h7fff_ffff, 16'sh7fff);
      queue_op(CMD_INSERT, 32'h8000_0000, 16'sh8000);
      queue_op(CMD_INSERT, 32'h0000_0000, 16'sh0);
      queue_op(CMD_INSERT, 32'hffff_ffff, 16'sh0);
      queue_op(CMD_INSERT, 32'h0000_0001, 16'sh0);
      queue_op(CMD_INSERT, 32'h5555_5555, 16'sh8000);
      queue_op(CMD_INSERT, 32'haaaa_aaaa, 16'sh7fff);
      for (int i = 0; i < 9; i++)
         queue_op(CMD_INSERT, $urandom, PRI_W'($urandom_range(0, 8) - 4));
      queue_op(CMD_INSERT, 32'h1234_5678, -16'sd1);
      for (int i = 0; i < 3; i++) queue_op(CMD_REMOVE, $urandom, PRI_W'($urandom));
      for (int i = 0; i < 4; i++) queue_op(CMD_INSERT, pick_value(), pick_prio());

      // random: runs that lean towards filling, draining or neither
      run_left = 0;
      insert_odds = 50;
      for (int i = 0; i < RANDOM_OPS; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
               0: insert_odds = 80;
               1: insert_odds = 20;
               default: insert_odds = 50;
            endcase
         end
         run_left--;
         if ($urandom_range(1, 100) <= insert_odds) queue_op(CMD_INSERT, pick_value(), pick_prio());
         else queue_op(CMD_REMOVE, $urandom, PRI_W'($urandom));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_ops.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      $display("ran %0d operations: %0d inserts (%0d refused as full), %0d removes (%0d empty)",
               n_insert + n_remove, n_insert, n_dropped, n_remove, n_underflow);
      $display("checked %0d result beats; queue held up to %0d entries", beats_checked, peak_count);
      if (errors == 0) begin
         $display("PASS sorted_priority_queue");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL sorted_priority_queue");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
sim/sorted_priority_queue_tb.sv
